>>> design/p2w_pkg.sv
`timescale 1ns / 1ps

package p2w_pkg;

    localparam int AREA_W = 24;
    localparam int XW     = 22;
    localparam int ANG_W  = 26;
    localparam int CS_W   = 33;
    localparam int RV_W   = 34;
    localparam int KQ_W   = 34;
    localparam int SQ_W   = 29;
    localparam int FQ_W   = 31;
    localparam int N_W    = 58;
    localparam int DVN_W  = 50;

    localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;
    localparam logic signed [CS_W-1:0]  KINV_Q30 = 33'sd652032874;
    localparam logic [33:0] PI_Q32 = 34'd13493037705;

    localparam int Q_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_FOCAL  = 3'd0,
        REG_SENSOR = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_CIRC   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [FQ_W-1:0] fq;
        logic [15:0]     circ;
        logic [12:0]     width;
        logic [12:0]     height;
    } cfg_t;

    function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> design/p2w_queue.sv
`timescale 1ns / 1ps

module p2w_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(p2w_pkg::Q_DEPTH);

    logic [WIDTH-1:0] mem_reg [p2w_pkg::Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full     = (count_reg == (PW+1)'(p2w_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/p2w_front.sv
`timescale 1ns / 1ps

module p2w_front #(
    parameter int PIXEL_BITS = 12,
    parameter int QW         = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [87:0]          s_axis_tdata,
    output logic                 push,
    output logic [QW-1:0]        push_data,
    input  logic                 q_full,
    output p2w_pkg::cfg_t        cfg
);

    localparam int PXW = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;
    localparam int AW  = p2w_pkg::ANG_W;

    logic [19:0] focal_reg;
    logic [16:0] sensor_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] circ_reg;

    logic        busy_reg;
    logic        load_reg;
    logic [5:0]  cnt_reg;
    logic [42:0] num_reg;
    logic [16:0] rem_reg;
    logic [42:0] quo_reg;
    logic [p2w_pkg::FQ_W-1:0] fq_reg;

    logic              wr_en;
    p2w_pkg::reg_idx_t idx;
    logic              restart;
    logic [16:0]       s_eff;
    logic [32:0]       fw;
    logic [42:0]       num_init;
    logic [17:0]       t;
    logic              ge;
    logic [16:0]       rem_next;
    logic [42:0]       quo_next;

    function automatic logic [AW:0] fold_angle(input logic signed [AW-1:0] a_in);
        logic signed [AW-1:0] a;
        logic                 neg;
        a   = a_in;
        neg = 1'b0;
        if (a > p2w_pkg::DEG180)
        begin
            a = a - p2w_pkg::DEG360;
        end
        if (a < -p2w_pkg::DEG180)
        begin
            a = a + p2w_pkg::DEG360;
        end
        if (a > p2w_pkg::DEG90)
        begin
            a   = a - p2w_pkg::DEG180;
            neg = 1'b1;
        end
        if (a < -p2w_pkg::DEG90)
        begin
            a   = a + p2w_pkg::DEG180;
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    assign wr_en   = psel && penable && pwrite;
    assign idx     = p2w_pkg::reg_idx_t'(paddr[4:2]);
    assign restart = wr_en && (idx == p2w_pkg::REG_FOCAL || idx == p2w_pkg::REG_SENSOR
                               || idx == p2w_pkg::REG_WIDTH);

    assign s_eff    = (sensor_reg == '0) ? 17'd1 : sensor_reg;
    assign fw       = 33'(focal_reg) * 33'(width_reg);
    assign num_init = {1'b0, fw, 9'b0} + 43'(s_eff[16:1]);

    assign t        = {rem_reg, num_reg[42]};
    assign ge       = (t >= {1'b0, s_eff});
    assign rem_next = ge ? 17'(t - {1'b0, s_eff}) : t[16:0];
    assign quo_next = {quo_reg[41:0], ge};

    always_comb
    begin
        case (idx)
            p2w_pkg::REG_FOCAL:  prdata = 32'(focal_reg);
            p2w_pkg::REG_SENSOR: prdata = 32'(sensor_reg);
            p2w_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            p2w_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            p2w_pkg::REG_CIRC:   prdata = 32'(circ_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= 20'd4000;
            sensor_reg <= 17'd6000;
            width_reg  <= 13'd1920;
            height_reg <= 13'd1080;
            circ_reg   <= 16'd100;
        end
        else if (wr_en)
        begin
            case (idx)
                p2w_pkg::REG_FOCAL:  focal_reg  <= pwdata[19:0];
                p2w_pkg::REG_SENSOR: sensor_reg <= pwdata[16:0];
                p2w_pkg::REG_WIDTH:  width_reg  <= pwdata[12:0];
                p2w_pkg::REG_HEIGHT: height_reg <= pwdata[12:0];
                p2w_pkg::REG_CIRC:   circ_reg   <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    // focal length in 1/512 pixel, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
            cnt_reg  <= '0;
            fq_reg   <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
            cnt_reg  <= 6'd43;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                fq_reg   <= (quo_next[42:31] != '0) ? {p2w_pkg::FQ_W{1'b1}}
                                                    : quo_next[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            num_reg <= num_init;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[41:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    logic [11:0]  px_in;
    logic [11:0]  py_in;
    logic [23:0]  area_in;
    logic [16:0]  pan_in;
    logic [15:0]  tilt_in;
    logic [AW:0]  pan_f;
    logic [AW:0]  tilt_f;

    assign px_in   = s_axis_tdata[11:0];
    assign py_in   = s_axis_tdata[23:12];
    assign area_in = s_axis_tdata[47:24];
    assign pan_in  = s_axis_tdata[64:48];
    assign tilt_in = s_axis_tdata[80:65];

    assign pan_f  = fold_angle($signed({pan_in[16], pan_in, 8'b0}));
    assign tilt_f = fold_angle($signed({{2{tilt_in[15]}}, tilt_in, 8'b0}));

    assign s_axis_tready = !busy_reg && !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign push_data     = {(area_in == '0), tilt_f, pan_f, area_in,
                            py_in[PXW-1:0], px_in[PXW-1:0]};

    assign cfg.fq     = fq_reg;
    assign cfg.circ   = circ_reg;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

>>> design/p2w_cordic.sv
`timescale 1ns / 1ps

module p2w_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [p2w_pkg::ANG_W-1:0]     ang_in,
    input  logic                                 neg_in,
    output logic signed [p2w_pkg::CS_W-1:0]      cos_out,
    output logic signed [p2w_pkg::CS_W-1:0]      sin_out
);

    localparam int CW = p2w_pkg::CS_W;
    localparam int AW = p2w_pkg::ANG_W;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [AW-1:0] a_reg [STEPS];
    logic                 n_reg [STEPS];
    logic signed [CW-1:0] x_next [STEPS];
    logic signed [CW-1:0] y_next [STEPS];
    logic signed [AW-1:0] a_next [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [CW-1:0] xi;
            logic signed [CW-1:0] yi;
            logic signed [AW-1:0] ai;
            logic                 ni;
            if (i == 0)
            begin : g_first
                assign xi = p2w_pkg::KINV_Q30;
                assign yi = '0;
                assign ai = ang_in;
                assign ni = neg_in;
            end
            else
            begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign ai = a_reg[i-1];
                assign ni = n_reg[i-1];
            end
            always_comb
            begin
                if (ai >= 0)
                begin
                    x_next[i] = xi - (yi >>> i);
                    y_next[i] = yi + (xi >>> i);
                    a_next[i] = ai - p2w_pkg::atan_tab(i);
                end
                else
                begin
                    x_next[i] = xi + (yi >>> i);
                    y_next[i] = yi - (xi >>> i);
                    a_next[i] = ai + p2w_pkg::atan_tab(i);
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= x_next[i];
                    y_reg[i] <= y_next[i];
                    a_reg[i] <= a_next[i];
                    n_reg[i] <= ni;
                end
            end
        end
    endgenerate

    assign cos_out = n_reg[STEPS-1] ? -x_reg[STEPS-1] : x_reg[STEPS-1];
    assign sin_out = n_reg[STEPS-1] ? -y_reg[STEPS-1] : y_reg[STEPS-1];

endmodule

>>> design/p2w_back.sv
`timescale 1ns / 1ps

module p2w_back #(
    parameter int PIXEL_BITS   = 12,
    parameter int CORDIC_STEPS = 16,
    parameter int QW           = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  p2w_pkg::cfg_t  cfg,
    input  logic           q_empty,
    input  logic [QW-1:0]  q_data,
    output logic           q_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [95:0]    m_axis_tdata,
    output logic           m_axis_tuser
);

    localparam int PXW = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;
    localparam int NS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int AW  = p2w_pkg::ANG_W;
    localparam int XW  = p2w_pkg::XW;
    localparam int CW  = p2w_pkg::CS_W;
    localparam int RW  = p2w_pkg::RV_W;
    localparam int KW  = p2w_pkg::KQ_W;
    localparam int KH  = KW / 2;
    localparam int SW  = p2w_pkg::SQ_W;
    localparam int NW  = p2w_pkg::N_W;
    localparam int SQ  = NW / 2;
    localparam int DV  = KW;
    localparam int L   = SQ + DV;
    localparam int DLY = L - NS - 3;

    localparam int O_PY   = PXW;
    localparam int O_AREA = 2 * PXW;
    localparam int O_PAN  = O_AREA + p2w_pkg::AREA_W;
    localparam int O_TILT = O_PAN + AW + 1;
    localparam int O_BAD  = O_TILT + AW + 1;

    logic en;
    logic out_valid_reg;

    assign en    = !out_valid_reg || m_axis_tready;
    assign q_pop = en && !q_empty;

    // entry fields
    logic [PXW-1:0]  e_px;
    logic [PXW-1:0]  e_py;
    logic [23:0]     e_area;
    logic [13:0]     dxw;
    logic [13:0]     dyh;

    assign e_px   = q_data[PXW-1:0];
    assign e_py   = q_data[O_PY +: PXW];
    assign e_area = q_data[O_AREA +: 24];
    assign dxw    = {{(13-PXW){1'b0}}, e_px, 1'b0} - {1'b0, cfg.width};
    assign dyh    = {{(13-PXW){1'b0}}, e_py, 1'b0} - {1'b0, cfg.height};

    // valid / bad chain through the square root and divider
    logic vld_reg [L+1];
    logic bad_reg [L+1];

    // stage zero
    logic signed [XW-1:0] x0_reg;
    logic signed [XW-1:0] y0_reg;
    logic signed [AW-1:0] pan0_reg;
    logic                 pann0_reg;
    logic signed [AW-1:0] tilt0_reg;
    logic                 tiltn0_reg;

    // square root
    logic [NW-1:0]   sq_n_reg    [SQ+1];
    logic [SW+1:0]   sq_rem_reg  [SQ+1];
    logic [SW-1:0]   sq_root_reg [SQ+1];
    logic [NW-1:0]   sq_n_next    [SQ+1];
    logic [SW+1:0]   sq_rem_next  [SQ+1];
    logic [SW-1:0]   sq_root_next [SQ+1];

    // divider
    logic [KW-1:0]   dv_n_reg   [DV];
    logic [SW-1:0]   dv_rem_reg [DV];
    logic [SW-1:0]   dv_s_reg   [DV];
    logic [KW-1:0]   dv_q_reg   [DV];
    logic [KW-1:0]   dv_n_next   [DV];
    logic [SW-1:0]   dv_rem_next [DV];
    logic [KW-1:0]   dv_q_bit    [DV];

    logic [p2w_pkg::DVN_W-1:0] dv_num;
    assign dv_num = {(19'({3'b0, cfg.circ} << 2) + 19'(cfg.circ)), 31'b0}
                    + 50'(sq_root_reg[SQ][SW-1:1]);

    genvar k;
    generate
        for (k = 1; k <= SQ; k++)
        begin : g_sq
            logic [SW+3:0] r4;
            logic [SW+3:0] trial;
            logic          ge;
            assign r4    = {sq_rem_reg[k-1], sq_n_reg[k-1][NW-1 -: 2]};
            assign trial = {2'b0, sq_root_reg[k-1], 2'b01};
            assign ge    = (r4 >= trial);
            assign sq_rem_next[k]  = ge ? (SW+2)'(r4 - trial) : (SW+2)'(r4);
            assign sq_root_next[k] = {sq_root_reg[k-1][SW-2:0], ge};
            assign sq_n_next[k]    = {sq_n_reg[k-1][NW-3:0], 2'b0};
        end
        assign sq_rem_next[0]  = '0;
        assign sq_root_next[0] = '0;
        assign sq_n_next[0]    = 58'(e_area) * 58'(p2w_pkg::PI_Q32);

        for (k = 0; k < DV; k++)
        begin : g_dv
            logic [SW-1:0] rin;
            logic [KW-1:0] nin;
            logic [SW-1:0] sin;
            logic [KW-1:0] qin;
            logic [SW:0]   t;
            logic          ge;
            if (k == 0)
            begin : g_first
                assign rin = SW'(dv_num[p2w_pkg::DVN_W-1:KW]);
                assign nin = dv_num[KW-1:0];
                assign sin = sq_root_reg[SQ];
                assign qin = '0;
            end
            else
            begin : g_rest
                assign rin = dv_rem_reg[k-1];
                assign nin = dv_n_reg[k-1];
                assign sin = dv_s_reg[k-1];
                assign qin = dv_q_reg[k-1];
            end
            assign t  = {rin, nin[KW-1]};
            assign ge = (t >= {1'b0, sin});
            assign dv_rem_next[k] = ge ? SW'(t - {1'b0, sin}) : t[SW-1:0];
            assign dv_n_next[k]   = {nin[KW-2:0], 1'b0};
            assign dv_q_bit[k]    = {qin[KW-2:0], ge};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[k] <= dv_rem_next[k];
                    dv_n_reg[k]   <= dv_n_next[k];
                    dv_s_reg[k]   <= sin;
                    dv_q_reg[k]   <= dv_q_bit[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= L; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !q_empty;
            for (int i = 1; i <= L; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_reg[0]    <= q_data[O_BAD];
            x0_reg        <= $signed({dxw, 8'b0});
            y0_reg        <= $signed({dyh, 8'b0});
            pan0_reg      <= $signed(q_data[O_PAN +: AW]);
            pann0_reg     <= q_data[O_PAN + AW];
            tilt0_reg     <= $signed(q_data[O_TILT +: AW]);
            tiltn0_reg    <= q_data[O_TILT + AW];
            for (int i = 1; i <= L; i++)
            begin
                bad_reg[i] <= bad_reg[i-1];
            end
            for (int i = 0; i <= SQ; i++)
            begin
                sq_n_reg[i]    <= sq_n_next[i];
                sq_rem_reg[i]  <= sq_rem_next[i];
                sq_root_reg[i] <= sq_root_next[i];
            end
        end
    end

    // rotation branch
    logic signed [CW-1:0] cp;
    logic signed [CW-1:0] sp;
    logic signed [CW-1:0] ct;
    logic signed [CW-1:0] st;

    p2w_cordic #(.STEPS(NS)) u_pan (
        .clk     (clk),
        .en      (en),
        .ang_in  (pan0_reg),
        .neg_in  (pann0_reg),
        .cos_out (cp),
        .sin_out (sp)
    );

    p2w_cordic #(.STEPS(NS)) u_tilt (
        .clk     (clk),
        .en      (en),
        .ang_in  (tilt0_reg),
        .neg_in  (tiltn0_reg),
        .cos_out (ct),
        .sin_out (st)
    );

    logic signed [XW-1:0] xd_reg [NS];
    logic signed [XW-1:0] yd_reg [NS];

    logic signed [XW+CW-1:0] yc_reg;
    logic signed [XW+CW-1:0] ys_reg;
    logic signed [64:0]      zs_reg;
    logic signed [64:0]      zc_reg;
    logic signed [XW-1:0]    xa_reg;
    logic signed [CW-1:0]    cpa_reg;
    logic signed [CW-1:0]    spa_reg;

    logic signed [RW-1:0]    y1_reg;
    logic signed [RW-1:0]    z1_reg;
    logic signed [XW-1:0]    xb_reg;
    logic signed [CW-1:0]    cpb_reg;
    logic signed [CW-1:0]    spb_reg;

    logic signed [XW+CW-1:0] xc_reg;
    logic signed [XW+CW-1:0] xs_reg;
    logic signed [RW+CW-1:0] zsp_reg;
    logic signed [RW+CW-1:0] zcp_reg;
    logic signed [RW-1:0]    y1c_reg;

    logic [3*RW-1:0] rvd_reg [DLY];

    logic signed [31:0]   zf;
    logic signed [65:0]   sum_y1;
    logic signed [65:0]   sum_z1;
    logic signed [67:0]   sum_rx;
    logic signed [67:0]   sum_rz;
    logic signed [RW-1:0] rx_next;
    logic signed [RW-1:0] rz_next;
    logic signed [RW-1:0] y1_next;
    logic signed [RW-1:0] z1_next;

    assign zf     = $signed({1'b0, cfg.fq});
    assign sum_y1 = 66'(yc_reg) - 66'(zs_reg) + 66'sd536870912;
    assign sum_z1 = 66'(ys_reg) + 66'(zc_reg) + 66'sd536870912;
    assign y1_next = RW'(sum_y1 >>> 30);
    assign z1_next = RW'(sum_z1 >>> 30);
    assign sum_rx = 68'(xc_reg) + 68'(zsp_reg) + 68'sd536870912;
    assign sum_rz = 68'(zcp_reg) - 68'(xs_reg) + 68'sd536870912;
    assign rx_next = RW'(sum_rx >>> 30);
    assign rz_next = RW'(sum_rz >>> 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= x0_reg;
            yd_reg[0] <= y0_reg;
            for (int i = 1; i < NS; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
            end
            yc_reg  <= yd_reg[NS-1] * ct;
            ys_reg  <= yd_reg[NS-1] * st;
            zs_reg  <= zf * st;
            zc_reg  <= zf * ct;
            xa_reg  <= xd_reg[NS-1];
            cpa_reg <= cp;
            spa_reg <= sp;
            y1_reg  <= y1_next;
            z1_reg  <= z1_next;
            xb_reg  <= xa_reg;
            cpb_reg <= cpa_reg;
            spb_reg <= spa_reg;
            xc_reg  <= xb_reg * cpb_reg;
            xs_reg  <= xb_reg * spb_reg;
            zsp_reg <= z1_reg * spb_reg;
            zcp_reg <= z1_reg * cpb_reg;
            y1c_reg <= y1_reg;
            rvd_reg[0] <= {-rz_next, -y1c_reg, rx_next};
            for (int i = 1; i < DLY; i++)
            begin
                rvd_reg[i] <= rvd_reg[i-1];
            end
        end
    end

    // scaling by kq and saturation
    logic [KW-1:0]        kq;
    logic [2*RW+KH-1:0]   plo_reg [3];
    logic [2*RW+KH-1:0]   phi_reg [3];
    logic                 sgn_reg [3];
    logic                 vld_m_reg;
    logic                 bad_m_reg;
    logic [31:0]          pos_reg [3];
    logic                 bad_out_reg;

    assign kq = dv_q_reg[DV-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic signed [RW-1:0] v;
                logic [RW-1:0]        m;
                logic [67:0]          full;
                logic [51:0]          p;
                logic [51:0]          lim;
                logic [31:0]          sat;
                v = $signed(rvd_reg[DLY-1][c*RW +: RW]);
                m = (v < 0) ? RW'(-v) : RW'(v);
                sgn_reg[c] <= (v < 0);
                plo_reg[c] <= (2*RW+KH)'(m) * (2*RW+KH)'(kq[KH-1:0]);
                phi_reg[c] <= (2*RW+KH)'(m) * (2*RW+KH)'(kq[KW-1:KH]);
                full = 68'(plo_reg[c]) + (68'(phi_reg[c]) << KH);
                p    = 52'((full + 68'd32768) >> 16);
                lim  = sgn_reg[c] ? 52'd2147483648 : 52'd2147483647;
                sat  = (p > lim) ? 32'(lim) : 32'(p);
                pos_reg[c] <= bad_m_reg ? 32'd0 : (sgn_reg[c] ? -sat : sat);
            end
            bad_m_reg   <= bad_reg[L];
            bad_out_reg <= bad_m_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_m_reg     <= vld_reg[L];
            out_valid_reg <= vld_m_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {pos_reg[2], pos_reg[1], pos_reg[0]};
    assign m_axis_tuser  = bad_out_reg;

endmodule

>>> design/pixel_to_world_position_core.sv
`timescale 1ns / 1ps

// pixel to world position: back-projects one blob per transfer to a 3d point
// input stream: one blob per transfer (pixel centre, area, pan, tilt angles)
// output stream: x, y, z in 1/256 mm, tuser flags a zero area (position zero)
// apb port holds focal length, sensor width, image size and object size
// throughput: one transfer per cycle when both sides keep up and no recompute runs
// the path from input transfer to output valid runs through the
//   29-stage square root followed by the 34-stage divider for the range scale
// a 4-entry queue parts input acceptance from the pipeline, so the input side
//   keeps taking transfers until the queue is full while the output is stalled
// output stall freezes the whole pipeline; the output register holds its data
// after reset, and after a write to focal length, sensor width or image width,
//   s_axis_tready stays low while the focal length in pixels is recomputed
//   one quotient bit per cycle
module pixel_to_world_position_core #(
    parameter int PIXEL_BITS   = 12,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_x, pixel_y, blob_area, pan_angle, tilt_angle, zero fill
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pos_x, pos_y, pos_z
    output logic [95:0] m_axis_tdata,
    // bad_area
    output logic        m_axis_tuser
);

    localparam int PXW = (PIXEL_BITS < 12) ? PIXEL_BITS : 12;
    localparam int QW  = 2 * PXW + p2w_pkg::AREA_W + 2 * (p2w_pkg::ANG_W + 1) + 1;

    logic           push;
    logic [QW-1:0]  push_data;
    logic           q_full;
    logic           q_pop;
    logic [QW-1:0]  q_data;
    logic           q_empty;
    p2w_pkg::cfg_t  cfg;

    assign pready = 1'b1;

    p2w_front #(.PIXEL_BITS(PIXEL_BITS), .QW(QW)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_data     (push_data),
        .q_full        (q_full),
        .cfg           (cfg)
    );

    p2w_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    p2w_back #(
        .PIXEL_BITS   (PIXEL_BITS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .QW           (QW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> design/p2w_checker.sv
`timescale 1ns / 1ps

module p2w_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [87:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output data changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad area transfer with nonzero position");

    a_recalc_block: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
        && (paddr[4:2] == p2w_pkg::REG_FOCAL || paddr[4:2] == p2w_pkg::REG_SENSOR
            || paddr[4:2] == p2w_pkg::REG_WIDTH)
        |=> !s_axis_tready)
        else $error("input taken while focal length is recomputed");

endmodule

bind pixel_to_world_position_core p2w_checker u_p2w_checker (.*);

>>> dv/pixel_to_world_position_core_tb.sv
`timescale 1ns / 1ps

module pixel_to_world_position_core_tb;

    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        logic [23:0] area;
        logic [16:0] pan;
        logic [15:0] tilt;
    } blob_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        bad;
    } position_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;

    pixel_to_world_position_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    longint unsigned focal_mirror;
    longint unsigned sensor_mirror;
    longint unsigned width_mirror;
    longint unsigned height_mirror;
    longint unsigned circ_mirror;

    blob_t     blob_pending[$];
    position_t position_due[$];
    blob_t     blob_cur;
    int        idle_pct;
    int        mismatches;
    int        watchdog;

    longint atan_deg[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic void pan_tilt_trig(input longint ang, output longint c,
                                          output longint s);
        longint a;
        longint x;
        longint y;
        longint t;
        bit     flip;
        a = ang * 256;
        x = 652032874;
        y = 0;
        flip = 0;
        if (a > 11796480) a -= 23592960;
        if (a < -11796480) a += 23592960;
        if (a > 5898240)
        begin
            a -= 11796480;
            flip = 1;
        end
        if (a < -5898240)
        begin
            a += 11796480;
            flip = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (a >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a -= atan_deg[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a += atan_deg[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - r - b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] range_scale(input longint v, input longint unsigned kq);
        bit              neg;
        longint unsigned m;
        longint unsigned lim;
        longint unsigned p;
        longint          r;
        neg = v < 0;
        m = neg ? longint'(-v) : v;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (kq != 0 && m > (64'hFFFFFFFFFFFFFFFF - 64'd32768) / kq)
            p = lim;
        else
            p = (m * kq + 64'd32768) >> 16;
        if (p > lim) p = lim;
        r = neg ? -longint'(p) : longint'(p);
        return r[31:0];
    endfunction

    function automatic position_t world_position(input blob_t b);
        position_t       o;
        longint          gx, gy, gz, cp, sp, ct, st, y1, z1, rx, rz;
        longint unsigned sw, fq, sq, kq;
        o = '{x: 0, y: 0, z: 0, bad: 1'b1};
        if (b.area == 0) return o;
        gx = 256 * (2 * longint'(b.px) - longint'(width_mirror));
        gy = 256 * (2 * longint'(b.py) - longint'(height_mirror));
        sw = (sensor_mirror != 0) ? sensor_mirror : 1;
        fq = (512 * focal_mirror * width_mirror + sw / 2) / sw;
        gz = (fq > 64'd2147483647) ? 64'sd2147483647 : longint'(fq);
        pan_tilt_trig(longint'($signed(b.pan)), cp, sp);
        pan_tilt_trig(longint'($signed(b.tilt)), ct, st);
        y1 = round_q30(gy * ct - gz * st);
        z1 = round_q30(gy * st + gz * ct);
        rx = round_q30(gx * cp + z1 * sp);
        rz = round_q30(z1 * cp - gx * sp);
        sq = root64(longint'(b.area) * 64'd13493037705);
        kq = ((5 * circ_mirror) * (64'd1 << 31) + sq / 2) / sq;
        o.x = range_scale(rx, kq);
        o.y = range_scale(-y1, kq);
        o.z = range_scale(-rz, kq);
        o.bad = 1'b0;
        return o;
    endfunction

    function automatic blob_t random_blob();
        blob_t b;
        int    sel;
        b.px = 12'($urandom);
        b.py = 12'($urandom);
        sel = $urandom_range(99);
        if (sel < 5)
            b.area = 0;
        else if (sel < 60)
            b.area = 24'($urandom_range(1, 4000));
        else
            b.area = 24'($urandom >> $urandom_range(8, 31));
        if (b.area == 0 && sel >= 5) b.area = 1;
        if ($urandom_range(99) < 80)
        begin
            b.pan = 17'($signed($urandom_range(0, 92160)) - 46080);
            b.tilt = 16'($signed($urandom_range(0, 46080)) - 23040);
        end
        else
        begin
            b.pan = 17'($urandom);
            b.tilt = 16'($urandom);
        end
        return b;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // input side driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                position_due.push_back(world_position(blob_cur));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (blob_pending.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    blob_cur = blob_pending.pop_front();
                    s_axis_tdata <= {7'd0, blob_cur.tilt, blob_cur.pan, blob_cur.area,
                                     blob_cur.py, blob_cur.px};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side monitor
    always @(posedge clk)
    begin
        position_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (position_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %h %b", m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = position_due.pop_front();
                    if (m_axis_tdata !== {want.z, want.y, want.x} || m_axis_tuser !== want.bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x %h y %h z %h bad %b, got x %h y %h z %h bad %b",
                                     want.x, want.y, want.z, want.bad, m_axis_tdata[31:0],
                                     m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (blob_pending.size() == 0 && position_due.size() == 0 && !s_axis_tvalid))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("pixel_to_world_position_core regression: fail");
            $finish;
        end
    end

    task automatic apb_write(input p2w_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            p2w_pkg::REG_FOCAL:  focal_mirror = val & 32'hFFFFF;
            p2w_pkg::REG_SENSOR: sensor_mirror = val & 32'h1FFFF;
            p2w_pkg::REG_WIDTH:  width_mirror = val & 32'h1FFF;
            p2w_pkg::REG_HEIGHT: height_mirror = val & 32'h1FFF;
            p2w_pkg::REG_CIRC:   circ_mirror = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (blob_pending.size() != 0 || s_axis_tvalid || position_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic setup(input logic [31:0] f, input logic [31:0] s, input logic [31:0] w,
                         input logic [31:0] h, input logic [31:0] c);
        drain();
        apb_write(p2w_pkg::REG_FOCAL, f);
        apb_write(p2w_pkg::REG_SENSOR, s);
        apb_write(p2w_pkg::REG_WIDTH, w);
        apb_write(p2w_pkg::REG_HEIGHT, h);
        apb_write(p2w_pkg::REG_CIRC, c);
    endtask

    task automatic push_random(input int n);
        repeat (n) blob_pending.push_back(random_blob());
    endtask

    task automatic push_directed();
        blob_pending.push_back('{0, 0, 1, 0, 0});
        blob_pending.push_back('{4095, 4095, 24'hFFFFFF, 0, 0});
        blob_pending.push_back('{960, 540, 0, 0, 0});
        blob_pending.push_back('{4095, 0, 100, 17'(-46080), 16'(23040)});
        blob_pending.push_back('{0, 4095, 100, 17'(46080), 16'(-23040)});
        blob_pending.push_back('{2000, 1000, 500, 17'h0FFFF, 16'h7FFF});
        blob_pending.push_back('{100, 3000, 500, 17'h10000, 16'h8000});
        blob_pending.push_back('{960, 540, 1, 17'(23040), 16'(23040)});
        blob_pending.push_back('{960, 540, 1, 17'(-23040), 16'(-23040)});
        blob_pending.push_back('{1234, 567, 2, 17'(46079), 16'(23041)});
        blob_pending.push_back('{4095, 4095, 1, 17'(23041), 16'(-23041)});
        blob_pending.push_back('{0, 0, 24'hFFFFFF, 17'h1FFFF, 16'hFFFF});
        blob_pending.push_back('{3000, 200, 0, 17'h1FFFF, 16'h7FFF});
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        idle_pct = 23;
        mismatches = 0;
        watchdog = 0;
        focal_mirror = 4000;
        sensor_mirror = 6000;
        width_mirror = 1920;
        height_mirror = 1080;
        circ_mirror = 100;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push_directed();
        push_random(120);
        drain();

        idle_pct = 0;
        push_random(120);
        drain();
        idle_pct = 23;

        setup(32'hFFFFFFFF, 0, 8191, 8191, 65535);
        push_directed();
        push_random(80);

        setup(0, 1, 0, 0, 0);
        push_directed();
        push_random(40);

        setup(1, 100000, 1, 1, 1);
        push_random(60);

        setup(1000000, 1, 4096, 4096, 65535);
        push_random(60);

        for (int p = 0; p < 4; p++)
        begin
            setup($urandom_range(1, 1000000), $urandom_range(1, 100000),
                  $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 65535));
            push_random(60);
        end

        setup(4000, 6000, 1920, 1080, 100);
        push_random(20);
        drain();

        if (mismatches == 0)
            $display("pixel_to_world_position_core regression: pass");
        else
            $display("pixel_to_world_position_core regression: fail");
        $finish;
    end

endmodule
